### hw/rtl/dss_pkg.sv
// Shared constants, types and the digit-to-segment table for the decimal
// seven-segment encoder. No dependencies.
package dss_pkg;

    localparam int ValueW    = 16;
    localparam int DigitW    = 4;
    localparam int SegW      = 8;
    localparam int NumDigits = 4;
    localparam int DigitsW   = NumDigits * DigitW;

    // Divide by ten: (v * 52429) >> 19 is exact for every 16-bit v.
    localparam logic [ValueW-1:0] RecipTen   = 16'd52429;
    localparam int                RecipShift = 19;
    localparam int                ProdW      = 2 * ValueW;
    localparam int                QuotW      = ProdW - RecipShift;

    typedef logic [ValueW-1:0]  value_t;
    typedef logic [DigitW-1:0]  digit_t;
    typedef logic [DigitsW-1:0] digits_t;
    typedef logic [SegW-1:0]    seg_t;

    localparam seg_t SegBlank = 8'hFF;

    localparam seg_t SegZero  = 8'b11000000;
    localparam seg_t SegOne   = 8'b11111001;
    localparam seg_t SegTwo   = 8'b10100100;
    localparam seg_t SegThree = 8'b10110000;
    localparam seg_t SegFour  = 8'b10011001;
    localparam seg_t SegFive  = 8'b10010010;
    localparam seg_t SegSix   = 8'b10000010;
    localparam seg_t SegSeven = 8'b11111000;
    localparam seg_t SegEight = 8'b10000000;
    localparam seg_t SegNine  = 8'b10011000;

    // Active-low segment pattern, decimal point off
    function automatic seg_t seg_code(input digit_t d);
        seg_t s;
        case (d)
            4'd0: s = SegZero;
            4'd1: s = SegOne;
            4'd2: s = SegTwo;
            4'd3: s = SegThree;
            4'd4: s = SegFour;
            4'd5: s = SegFive;
            4'd6: s = SegSix;
            4'd7: s = SegSeven;
            4'd8: s = SegEight;
            4'd9: s = SegNine;
            default: s = SegBlank;
        endcase
        return s;
    endfunction

endpackage

### hw/rtl/dss_cell.sv
// One divide-by-ten cell of the digit chain: peels off the lowest decimal
// digit and hands the quotient on. Depends on dss_pkg.
module dss_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             valid_i,
    input  dss_pkg::value_t  value_i,
    input  dss_pkg::digits_t digits_i,
    output logic             valid_o,
    output dss_pkg::value_t  value_o,
    output dss_pkg::digits_t digits_o
);

    logic             valid_reg;
    dss_pkg::value_t  value_reg;
    dss_pkg::value_t  value_next;
    dss_pkg::digits_t digits_reg;
    dss_pkg::digits_t digits_next;

    logic [dss_pkg::ProdW-1:0] prod;
    logic [dss_pkg::QuotW-1:0] quot;
    dss_pkg::value_t           times_ten;
    dss_pkg::value_t           rem;

    always_comb begin
        prod       = dss_pkg::ProdW'(value_i) * dss_pkg::ProdW'(dss_pkg::RecipTen);
        quot       = prod[dss_pkg::ProdW-1:dss_pkg::RecipShift];
        value_next = dss_pkg::ValueW'(quot);
        times_ten  = (value_next << 3) + (value_next << 1);
        rem        = value_i - times_ten;
        // shift the new digit in at the top; after the last cell the
        // ones digit sits lowest
        digits_next = {rem[dss_pkg::DigitW-1:0],
                       digits_i[dss_pkg::DigitsW-1:dss_pkg::DigitW]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && valid_i) begin
            value_reg  <= value_next;
            digits_reg <= digits_next;
        end
    end

    assign valid_o  = valid_reg;
    assign value_o  = value_reg;
    assign digits_o = digits_reg;

endmodule

### hw/rtl/dss_encode.sv
// Segment encoding with leading-zero blanking for the four digits held at
// the end of the chain. Depends on dss_pkg.
module dss_encode (
    input  dss_pkg::digits_t digits_i,
    output dss_pkg::seg_t    ones_seg_o,
    output dss_pkg::seg_t    tens_seg_o,
    output dss_pkg::seg_t    hundreds_seg_o,
    output dss_pkg::seg_t    thousands_seg_o
);

    dss_pkg::digit_t d0, d1, d2, d3;
    logic            blank3, blank2, blank1;

    always_comb begin
        d0 = digits_i[1*dss_pkg::DigitW-1:0*dss_pkg::DigitW];
        d1 = digits_i[2*dss_pkg::DigitW-1:1*dss_pkg::DigitW];
        d2 = digits_i[3*dss_pkg::DigitW-1:2*dss_pkg::DigitW];
        d3 = digits_i[4*dss_pkg::DigitW-1:3*dss_pkg::DigitW];

        // blank downwards until the first nonzero digit; ones always shows
        blank3 = (d3 == '0);
        blank2 = blank3 && (d2 == '0);
        blank1 = blank2 && (d1 == '0);

        ones_seg_o      = dss_pkg::seg_code(d0);
        tens_seg_o      = blank1 ? dss_pkg::SegBlank : dss_pkg::seg_code(d1);
        hundreds_seg_o  = blank2 ? dss_pkg::SegBlank : dss_pkg::seg_code(d2);
        thousands_seg_o = blank3 ? dss_pkg::SegBlank : dss_pkg::seg_code(d3);
    end

endmodule

### hw/rtl/decimal_seven_segment_encoder.sv
// Channel   Direction  Ports
// s_        in         s_valid, s_ready, s_value[15:0]
// m_        out        m_valid, m_ready, m_{ones,tens,hundreds,thousands}_segments[7:0]
//
// Four divide-by-ten cells in a chain, one register stage each; the segment
// encoder reads the last stage. One item a cycle is taken and delivered
// while the output is not stalled; the chain's cells set that rate.
// A stall on m_ready freezes the whole chain; s_ready is low only while a
// result waits untaken. Synchronous reset empties the whole chain at once.
// Depends on dss_pkg, dss_cell and dss_encode.
module decimal_seven_segment_encoder (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [15:0]           s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_ones_segments,
    output logic [7:0]            m_tens_segments,
    output logic [7:0]            m_hundreds_segments,
    output logic [7:0]            m_thousands_segments
);

    logic             adv;
    logic             valid_w  [dss_pkg::NumDigits+1];
    dss_pkg::value_t  value_w  [dss_pkg::NumDigits+1];
    dss_pkg::digits_t digits_w [dss_pkg::NumDigits+1];

    // advance whenever the last stage is empty or being taken
    assign adv     = m_ready || !valid_w[dss_pkg::NumDigits];
    assign s_ready = adv;

    assign valid_w[0]  = s_valid;
    assign value_w[0]  = s_value;
    assign digits_w[0] = '0;

    for (genvar i = 0; i < dss_pkg::NumDigits; i++) begin : g_cell
        dss_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .valid_i  (valid_w[i]),
            .value_i  (value_w[i]),
            .digits_i (digits_w[i]),
            .valid_o  (valid_w[i+1]),
            .value_o  (value_w[i+1]),
            .digits_o (digits_w[i+1])
        );
    end

    dss_encode u_encode (
        .digits_i        (digits_w[dss_pkg::NumDigits]),
        .ones_seg_o      (m_ones_segments),
        .tens_seg_o      (m_tens_segments),
        .hundreds_seg_o  (m_hundreds_segments),
        .thousands_seg_o (m_thousands_segments)
    );

    assign m_valid = valid_w[dss_pkg::NumDigits];

endmodule

### hw/rtl/dss_checker.sv
// Port-level checks for the decimal seven-segment encoder, bound to the
// top level. Depends on decimal_seven_segment_encoder.
module dss_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [15:0] s_value,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_ones_segments,
    input logic [7:0] m_tens_segments,
    input logic [7:0] m_hundreds_segments,
    input logic [7:0] m_thousands_segments
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (m_ready || !m_valid))
        else $error("input stalled while output free");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ones_segments)
            && $stable(m_tens_segments) && $stable(m_hundreds_segments)
            && $stable(m_thousands_segments))
        else $error("stalled result changed");

    a_blank_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tens_segments == 8'hFF
            |-> m_hundreds_segments == 8'hFF && m_thousands_segments == 8'hFF)
        else $error("blanking not contiguous from the top");

    a_ones_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_ones_segments != 8'hFF && m_ones_segments[7])
        else $error("ones digit blanked or point lit");

endmodule

bind decimal_seven_segment_encoder dss_checker u_dss_checker (.*);
